>>> rtl/core/cfc_pkg.sv
// Shared types, register codes and the CRC-32 byte update for the frame checker.
package cfc_pkg;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_START_FIRST  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_START_SECOND = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_END_FIRST    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_END_SECOND   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_PAYLOAD  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_FRAME    = 3'd5;

    localparam logic [7:0]  RST_START_FIRST  = 8'hAA;
    localparam logic [7:0]  RST_START_SECOND = 8'h55;
    localparam logic [7:0]  RST_END_FIRST    = 8'h0D;
    localparam logic [7:0]  RST_END_SECOND   = 8'h0A;
    localparam logic [15:0] RST_MAX_PAYLOAD  = 16'd1024;
    localparam logic [15:0] RST_MIN_FRAME    = 16'd11;

    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    localparam logic [15:0] HEADER_BYTES   = 16'd5;
    localparam logic [16:0] OVERHEAD_BYTES = 17'd11;
    localparam logic [15:0] COUNT_MAX      = 16'hFFFF;

    typedef enum logic [2:0] {
        KIND_START0,
        KIND_START1,
        KIND_CMD,
        KIND_LEN_HI,
        KIND_LEN_LO,
        KIND_BODY
    } byte_kind_t;

    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        byte_kind_t  kind;
        logic        crc_en;
        logic [15:0] byte_total;
        logic        overlong;
    } byte_rec_t;

    typedef struct packed {
        logic [7:0]  start_first;
        logic [7:0]  start_second;
        logic [7:0]  end_first;
        logic [7:0]  end_second;
        logic [15:0] max_payload;
        logic [15:0] min_frame;
    } cfg_t;

    // Reflected CRC-32, one byte, LSB first
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'h0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> rtl/core/crc32_frame_checker_unit.sv
// Top level of the CRC-32 frame checker: configuration registers and the front/back split.
//
// Frame bytes enter on data_byte with last_byte set on the final byte; a byte is
// taken when push is high and full is low. One verdict per frame comes out on
// frame_ok and command_code, held while empty is low and taken when pop is high.
// A byte is accepted every cycle while full is low. The front end tags each byte
// with its frame position in the cycle it arrives and queues it; the back end takes
// it from the queue, updates the CRC and checks the frame, so empty falls at the edge
// where the back end takes the last byte, which waits until the result register is free.
// The byte-wide CRC update in the back end sets the one-byte-per-cycle rate.
// Writes on cfg_write/cfg_index/cfg_data take effect at the next edge; indexes
// past the register list are dropped. Reset loads the register defaults, clears
// all per-frame state and empties the tag queue and the result register. While
// the receiver holds off pop, the result register keeps its verdict and bytes of
// the next frame keep flowing until that frame's last byte reaches the back end;
// the tag queue then fills and full rises until pop frees the result register.
module crc32_frame_checker_unit #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic [7:0]                       data_byte,
    input  logic                             last_byte,
    output logic                             empty,
    input  logic                             pop,
    output logic                             frame_ok,
    output logic [7:0]                       command_code,
    input  logic                             cfg_write,
    input  logic [cfc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [cfc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import cfc_pkg::*;

    cfg_t      cfg_reg;
    byte_rec_t front_rec;
    byte_rec_t q_rec;
    logic      q_valid;
    logic      back_take;
    logic      accept;
    logic      out_valid;

    assign accept = push && !full;
    assign empty  = !out_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_first  <= RST_START_FIRST;
            cfg_reg.start_second <= RST_START_SECOND;
            cfg_reg.end_first    <= RST_END_FIRST;
            cfg_reg.end_second   <= RST_END_SECOND;
            cfg_reg.max_payload  <= RST_MAX_PAYLOAD;
            cfg_reg.min_frame    <= RST_MIN_FRAME;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_START_FIRST:  cfg_reg.start_first  <= cfg_data[7:0];
                REG_START_SECOND: cfg_reg.start_second <= cfg_data[7:0];
                REG_END_FIRST:    cfg_reg.end_first    <= cfg_data[7:0];
                REG_END_SECOND:   cfg_reg.end_second   <= cfg_data[7:0];
                REG_MAX_PAYLOAD:  cfg_reg.max_payload  <= cfg_data;
                REG_MIN_FRAME:    cfg_reg.min_frame    <= cfg_data;
                default:          ;
            endcase
        end
    end

    cfc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .rec       (front_rec)
    );

    cfc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (accept),
        .wr_rec (front_rec),
        .full   (full),
        .rd_en  (back_take),
        .rd_rec (q_rec),
        .valid  (q_valid)
    );

    cfc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .rec_valid    (q_valid),
        .rec          (q_rec),
        .rec_take     (back_take),
        .pop          (pop),
        .out_valid    (out_valid),
        .frame_ok     (frame_ok),
        .command_code (command_code)
    );

    // A last byte taken by the back end always leaves a result waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        back_take && q_rec.last |=> !empty)
        else $error("last byte taken without a result");

    // Overlong frames never pass
    assert property (@(posedge clk) disable iff (!rst_n)
        back_take && q_rec.last && q_rec.overlong |=> !frame_ok)
        else $error("overlong frame reported valid");

    // The first byte of a frame carries a count of one and no overflow
    assert property (@(posedge clk) disable iff (!rst_n)
        q_valid && (q_rec.kind == KIND_START0)
            |-> (q_rec.byte_total == 16'd1) && !q_rec.overlong)
        else $error("frame start tagged with a stale count");

    // Nothing is taken from an empty tag queue
    assert property (@(posedge clk) disable iff (!rst_n)
        back_take |-> q_valid)
        else $error("back end read an empty queue");

endmodule

>>> rtl/core/cfc_front.sv
// Front end: counts frame bytes and tags each one with its place in the frame.
module cfc_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [7:0]         data_byte,
    input  logic               last_byte,
    output cfc_pkg::byte_rec_t rec
);
    import cfc_pkg::*;

    logic [15:0] count_reg, count_next;
    logic [15:0] plen_reg, plen_next;
    logic        overlong_reg, overlong_next;
    byte_kind_t  kind;
    logic        crc_en;

    always_comb
    begin
        unique case (count_reg)
            16'd0:   kind = KIND_START0;
            16'd1:   kind = KIND_START1;
            16'd2:   kind = KIND_CMD;
            16'd3:   kind = KIND_LEN_HI;
            16'd4:   kind = KIND_LEN_LO;
            default: kind = KIND_BODY;
        endcase
    end

    // Header always enters the CRC; the body only up to the declared payload length
    assign crc_en = (count_reg < HEADER_BYTES) ||
                    ({1'b0, count_reg} < ({1'b0, HEADER_BYTES} + {1'b0, plen_reg}));

    always_comb
    begin
        plen_next     = plen_reg;
        overlong_next = overlong_reg;
        count_next    = count_reg;
        if (kind == KIND_LEN_HI)
        begin
            plen_next = {data_byte, 8'h00};
        end
        else if (kind == KIND_LEN_LO)
        begin
            plen_next = {plen_reg[15:8], data_byte};
        end
        // saturate the count and flag the frame instead
        if (count_reg == COUNT_MAX)
        begin
            overlong_next = 1'b1;
        end
        else
        begin
            count_next = count_reg + 16'd1;
        end
    end

    always_comb
    begin
        rec.data       = data_byte;
        rec.last       = last_byte;
        rec.kind       = kind;
        rec.crc_en     = crc_en;
        rec.byte_total = count_next;
        rec.overlong   = overlong_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            plen_reg     <= '0;
            overlong_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                count_reg    <= '0;
                plen_reg     <= '0;
                overlong_reg <= 1'b0;
            end
            else
            begin
                count_reg    <= count_next;
                plen_reg     <= plen_next;
                overlong_reg <= overlong_next;
            end
        end
    end

endmodule

>>> rtl/core/cfc_queue.sv
// Short queue of tagged bytes between the front and back ends.
module cfc_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  cfc_pkg::byte_rec_t wr_rec,
    output logic               full,
    input  logic               rd_en,
    output cfc_pkg::byte_rec_t rd_rec,
    output logic               valid
);
    import cfc_pkg::*;

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    byte_rec_t        entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full   = (count_reg == CNT_W'(DEPTH));
    assign valid  = (count_reg != '0);
    assign rd_rec = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= wr_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!wr_en && rd_en)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> rtl/core/cfc_back.sv
// Back end: running CRC, header capture, tail window and the frame verdict.
module cfc_back (
    input  logic               clk,
    input  logic               rst_n,
    input  cfc_pkg::cfg_t      cfg,
    input  logic               rec_valid,
    input  cfc_pkg::byte_rec_t rec,
    output logic               rec_take,
    input  logic               pop,
    output logic               out_valid,
    output logic               frame_ok,
    output logic [7:0]         command_code
);
    import cfc_pkg::*;

    logic [31:0] crc_reg, crc_next;
    logic [47:0] tail_reg, tail_next;
    logic        match_reg, match_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [15:0] plen_reg, plen_next;
    logic        out_valid_reg;
    logic        ok_reg;
    logic [7:0]  cmd_out_reg;
    logic        verdict;

    // A last byte needs the result register free; other bytes always drain
    assign rec_take  = rec_valid && (!rec.last || !out_valid_reg || pop);
    assign out_valid = out_valid_reg;
    assign frame_ok  = ok_reg;
    assign command_code = cmd_out_reg;

    always_comb
    begin
        match_next = match_reg;
        cmd_next   = cmd_reg;
        plen_next  = plen_reg;
        unique case (rec.kind)
            KIND_START0: match_next = (rec.data == cfg.start_first);
            KIND_START1: match_next = match_reg && (rec.data == cfg.start_second);
            KIND_CMD:    cmd_next   = rec.data;
            KIND_LEN_HI: plen_next  = {rec.data, 8'h00};
            KIND_LEN_LO: plen_next  = {plen_reg[15:8], rec.data};
            default:     ;
        endcase
        crc_next  = rec.crc_en ? crc32_byte(crc_reg, rec.data) : crc_reg;
        tail_next = {tail_reg[39:0], rec.data};
    end

    always_comb
    begin
        verdict = !rec.overlong
            && (rec.byte_total >= cfg.min_frame)
            && match_next
            && (tail_next[15:8] == cfg.end_first)
            && (tail_next[7:0] == cfg.end_second)
            && (plen_next <= cfg.max_payload)
            && ({1'b0, rec.byte_total} == ({1'b0, plen_next} + OVERHEAD_BYTES))
            && ((crc_next ^ CRC_INIT) == tail_next[47:16]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg   <= CRC_INIT;
            tail_reg  <= '0;
            match_reg <= 1'b0;
            cmd_reg   <= '0;
            plen_reg  <= '0;
        end
        else if (rec_take)
        begin
            if (rec.last)
            begin
                crc_reg   <= CRC_INIT;
                tail_reg  <= '0;
                match_reg <= 1'b0;
                cmd_reg   <= '0;
                plen_reg  <= '0;
            end
            else
            begin
                crc_reg   <= crc_next;
                tail_reg  <= tail_next;
                match_reg <= match_next;
                cmd_reg   <= cmd_next;
                plen_reg  <= plen_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (rec_take && rec.last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rec_take && rec.last)
        begin
            ok_reg      <= verdict;
            cmd_out_reg <= cmd_next;
        end
    end

endmodule

>>> verif/crc32_frame_checker_unit_test.sv
// Self-checking testbench for the CRC-32 frame checker: stimulus, predictor, verdict checks.
module crc32_frame_checker_unit_test;
    import cfc_pkg::*;

    localparam int CLK_HALF = 5;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_SHOWN = 10;
    localparam int RANDOM_BYTES = 900;
    localparam int FRAMES_PER_SETTING = 12;

    // Indexes past the register list; the block must drop these writes
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_HI = 3'd7;

    typedef logic [7:0] byte_q_t[$];

    typedef struct packed {
        logic       ok;
        logic [7:0] cmd;
    } verdict_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   push = 1'b0;
    logic [7:0]             data_byte = '0;
    logic                   last_byte = 1'b0;
    logic                   pop = 1'b0;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   full;
    logic                   empty;
    logic                   frame_ok;
    logic [7:0]             command_code;

    crc32_frame_checker_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .empty        (empty),
        .pop          (pop),
        .frame_ok     (frame_ok),
        .command_code (command_code),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    // Register shadow and per-frame predictor state
    cfg_t        shadow_cfg;
    logic [15:0] rx_count;
    logic [31:0] rx_crc;
    logic [47:0] rx_tail;
    logic        rx_start_ok;
    logic [7:0]  rx_cmd;
    logic [15:0] rx_plen;
    logic        rx_overlong;

    verdict_t    verdict_q[$];

    int unsigned cycle_count = 0;
    int          mismatches = 0;
    int          verdicts_seen = 0;
    int          good_seen = 0;
    int          bytes_sent = 0;
    int          frames_sent = 0;
    int          burst_left = 0;
    bit          sender_steady = 1'b0;
    int          stall_mode = 0;
    int unsigned stall_tick = 0;

    function automatic logic [31:0] crc32_update(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] r;
        r = crc;
        for (int i = 0; i < 8; i++) begin
            r = (r >> 1) ^ ((r[0] ^ b[i]) ? CRC_POLY : 32'h0);
        end
        return r;
    endfunction

    function automatic void frame_state_clear();
        rx_count    = '0;
        rx_crc      = CRC_INIT;
        rx_tail     = '0;
        rx_start_ok = 1'b0;
        rx_cmd      = '0;
        rx_plen     = '0;
        rx_overlong = 1'b0;
    endfunction

    // Advance the predictor by one accepted byte; queue a verdict on the last byte
    function automatic void predict_byte(input logic [7:0] b, input logic is_last);
        logic [16:0] len_sum;
        verdict_t    v;
        case (rx_count)
            16'd0: rx_start_ok = (b == shadow_cfg.start_first);
            16'd1: rx_start_ok = rx_start_ok && (b == shadow_cfg.start_second);
            16'd2: rx_cmd = b;
            16'd3: rx_plen = {b, 8'h00};
            16'd4: rx_plen = {rx_plen[15:8], b};
            default: ;
        endcase
        if ({1'b0, rx_count} < {1'b0, HEADER_BYTES} + {1'b0, rx_plen})
            rx_crc = crc32_update(rx_crc, b);
        rx_tail = {rx_tail[39:0], b};
        if (rx_count == COUNT_MAX)
            rx_overlong = 1'b1;
        else
            rx_count = rx_count + 16'd1;
        if (is_last) begin
            len_sum = {1'b0, rx_plen} + OVERHEAD_BYTES;
            v.ok = !rx_overlong
                && rx_count >= shadow_cfg.min_frame
                && rx_start_ok
                && rx_tail[15:8] == shadow_cfg.end_first
                && rx_tail[7:0] == shadow_cfg.end_second
                && rx_plen <= shadow_cfg.max_payload
                && {1'b0, rx_count} == len_sum
                && ~rx_crc == rx_tail[47:16];
            v.cmd = rx_cmd;
            verdict_q.push_back(v);
            frame_state_clear();
        end
    endfunction

    function automatic void flag_mismatch(input string what, input int want, input int got);
        mismatches++;
        if (mismatches <= MAX_SHOWN)
            $display("mismatch on %s at cycle %0d: expected %0d, got %0d",
                     what, cycle_count, want, got);
    endfunction

    function automatic void check_verdict(input logic got_ok, input logic [7:0] got_cmd);
        verdict_t want;
        verdicts_seen++;
        if (got_ok === 1'b1)
            good_seen++;
        if (verdict_q.size() == 0) begin
            flag_mismatch("verdict with none pending", 0, 1);
            return;
        end
        want = verdict_q.pop_front();
        if (got_ok !== want.ok)
            flag_mismatch("frame_ok", want.ok, got_ok);
        if (got_cmd !== want.cmd)
            flag_mismatch("command_code", want.cmd, got_cmd);
    endfunction

    // Receiver: check each taken verdict, then pick pop from the current stall pattern
    always @(posedge clk) begin
        if (rst_n && pop && !empty)
            check_verdict(frame_ok, command_code);
        stall_tick++;
        if (stall_tick % 256 == 0)
            stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: pop <= 1'b1;
            1: pop <= 1'($urandom_range(0, 1));
            2: pop <= ($urandom_range(0, 9) == 0);
            default: pop <= ((stall_tick % 24) < 4);
        endcase
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d verdicts pending",
                     cycle_count, verdict_q.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // Send one byte; gaps open only between bursts
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        if (!sender_steady) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                if ($urandom_range(0, 3) != 0) begin
                    push <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(posedge clk);
                end
            end
            burst_left--;
        end
        push      <= 1'b1;
        data_byte <= b;
        last_byte <= is_last;
        do @(posedge clk); while (full !== 1'b0);
        predict_byte(b, is_last);
        bytes_sent++;
    endtask

    task automatic send_frame(input byte_q_t fr);
        foreach (fr[i])
            send_byte(fr[i], i == fr.size() - 1);
        frames_sent++;
    endtask

    function automatic byte_q_t build_frame(input logic [7:0] cmd, input logic [15:0] plen);
        byte_q_t     fr;
        logic [31:0] c;
        fr.push_back(shadow_cfg.start_first);
        fr.push_back(shadow_cfg.start_second);
        fr.push_back(cmd);
        fr.push_back(plen[15:8]);
        fr.push_back(plen[7:0]);
        for (int i = 0; i < plen; i++)
            fr.push_back(8'($urandom));
        c = CRC_INIT;
        foreach (fr[i])
            c = crc32_update(c, fr[i]);
        c = ~c;
        fr.push_back(c[31:24]);
        fr.push_back(c[23:16]);
        fr.push_back(c[15:8]);
        fr.push_back(c[7:0]);
        fr.push_back(shadow_cfg.end_first);
        fr.push_back(shadow_cfg.end_second);
        return fr;
    endfunction

    // Hold until every verdict is back and the pipeline has drained
    task automatic wait_idle();
        push <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_START_FIRST:  shadow_cfg.start_first  = val[7:0];
            REG_START_SECOND: shadow_cfg.start_second = val[7:0];
            REG_END_FIRST:    shadow_cfg.end_first    = val[7:0];
            REG_END_SECOND:   shadow_cfg.end_second   = val[7:0];
            REG_MAX_PAYLOAD:  shadow_cfg.max_payload  = val;
            REG_MIN_FRAME:    shadow_cfg.min_frame    = val;
            default: ;
        endcase
    endtask

    // Load all six registers; junk goes in the unused upper byte of the 8-bit ones
    task automatic load_setting(input logic [7:0] sf, input logic [7:0] ss, input logic [7:0] ef,
                                input logic [7:0] es, input logic [15:0] maxp,
                                input logic [15:0] minf);
        wait_idle();
        write_reg(REG_START_FIRST, {8'($urandom), sf});
        write_reg(REG_START_SECOND, {8'($urandom), ss});
        write_reg(REG_END_FIRST, {8'($urandom), ef});
        write_reg(REG_END_SECOND, {8'($urandom), es});
        write_reg(REG_MAX_PAYLOAD, maxp);
        write_reg(REG_MIN_FRAME, minf);
    endtask

    task automatic test_defaults();
        byte_q_t fr;
        send_frame(build_frame(8'h00, 16'd0));
        send_frame(build_frame(8'hFF, 16'd1));
        send_frame(build_frame(8'($urandom), 16'd7));
        // corrupt CRC, start bytes and end bytes one at a time
        fr = build_frame(8'h11, 16'd4);
        fr[fr.size() - 3] ^= 8'h01;
        send_frame(fr);
        fr = build_frame(8'h12, 16'd2);
        fr[0] ^= 8'h80;
        send_frame(fr);
        fr = build_frame(8'h13, 16'd2);
        fr[1] ^= 8'h01;
        send_frame(fr);
        fr = build_frame(8'h14, 16'd2);
        fr[fr.size() - 2] ^= 8'h40;
        send_frame(fr);
        fr = build_frame(8'h15, 16'd2);
        fr[fr.size() - 1] ^= 8'h02;
        send_frame(fr);
        send_frame(build_frame(8'h16, RST_MAX_PAYLOAD + 16'd1));
        // body longer and shorter than the header claims
        fr = build_frame(8'h17, 16'd3);
        fr.insert(6, 8'h5A);
        send_frame(fr);
        fr = build_frame(8'h18, 16'd3);
        fr.delete(5);
        send_frame(fr);
        // frames too short to carry header and trailer
        fr = build_frame(8'h19, 16'd0);
        send_frame(fr[0:0]);
        send_frame(fr[0:1]);
        send_frame(fr[0:2]);
        fr = fr[0:9];
        fr[8] = shadow_cfg.end_first;
        fr[9] = shadow_cfg.end_second;
        send_frame(fr);
        // all-ones length must not wrap into a match
        fr = build_frame(8'h1A, 16'd0);
        fr[3] = 8'hFF;
        fr[4] = 8'hFF;
        send_frame(fr);
        // minimum below the fixed overhead still rejects short frames
        wait_idle();
        write_reg(REG_MIN_FRAME, 16'd0);
        fr = build_frame(8'h1B, 16'd0);
        fr = fr[0:9];
        fr[8] = shadow_cfg.end_first;
        fr[9] = shadow_cfg.end_second;
        send_frame(fr);
        send_frame(build_frame(8'h1C, 16'd0));
        // writes past the register list change nothing
        wait_idle();
        write_reg(REG_UNUSED_LO, 16'($urandom));
        write_reg(REG_UNUSED_HI, 16'hFFFF);
        write_reg(REG_MIN_FRAME, RST_MIN_FRAME);
        send_frame(build_frame(8'h1D, 16'd5));
    endtask

    task automatic test_register_extremes();
        byte_q_t fr;
        load_setting(8'h00, 8'hFF, 8'hFF, 8'h00, 16'd0, 16'd11);
        send_frame(build_frame(8'h21, 16'd0));
        send_frame(build_frame(8'h22, 16'd1));
        load_setting(8'hFF, 8'h00, 8'h00, 8'hFF, 16'hFFFF, 16'hFFFF);
        send_frame(build_frame(8'h23, 16'd3));
        // minimum exactly at the frame length, then one past it
        load_setting(8'h5A, 8'hA5, 8'h7E, 8'h81, 16'd3, 16'd14);
        send_frame(build_frame(8'h24, 16'd3));
        send_frame(build_frame(8'h25, 16'd4));
        wait_idle();
        write_reg(REG_MIN_FRAME, 16'd15);
        send_frame(build_frame(8'h26, 16'd3));
        fr = build_frame(8'h27, 16'd6);
        fr[2] = 8'hC3;
        send_frame(fr);
    endtask

    task automatic random_setting();
        logic [15:0] maxp;
        logic [15:0] minf;
        case ($urandom_range(0, 5))
            0: maxp = 16'd0;
            1: maxp = 16'd65524;
            2: maxp = 16'hFFFF;
            default: maxp = 16'($urandom_range(200, 4000));
        endcase
        case ($urandom_range(0, 3))
            0: minf = 16'd0;
            1: minf = 16'($urandom_range(11, 40));
            default: minf = RST_MIN_FRAME;
        endcase
        load_setting(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), maxp, minf);
        sender_steady = ($urandom_range(0, 3) == 0);
    endtask

    task automatic test_random_traffic();
        byte_q_t fr;
        int      first_byte;
        int      n;
        int      kind;
        int      pos;
        first_byte = bytes_sent;
        n = 0;
        while (bytes_sent - first_byte < RANDOM_BYTES) begin
            if (n % FRAMES_PER_SETTING == 0)
                random_setting();
            n++;
            kind = $urandom_range(0, 9);
            fr = build_frame(8'($urandom), 16'($urandom_range(0, (kind == 0) ? 200 : 24)));
            case (kind)
                6: begin
                    pos = $urandom_range(0, fr.size() - 1);
                    fr[pos] ^= 8'($urandom_range(1, 255));
                end
                7: begin
                    pos = $urandom_range(0, fr.size() - 1);
                    if ($urandom_range(0, 1))
                        fr.delete(pos);
                    else
                        fr.insert(pos, 8'($urandom));
                end
                8: begin
                    fr.delete();
                    repeat ($urandom_range(1, 20)) fr.push_back(8'($urandom));
                end
                9: begin
                    fr[3] = 8'($urandom);
                    fr[4] = 8'($urandom);
                end
                default: ;
            endcase
            send_frame(fr);
        end
        sender_steady = 1'b0;
    endtask

    initial begin
        shadow_cfg.start_first  = RST_START_FIRST;
        shadow_cfg.start_second = RST_START_SECOND;
        shadow_cfg.end_first    = RST_END_FIRST;
        shadow_cfg.end_second   = RST_END_SECOND;
        shadow_cfg.max_payload  = RST_MAX_PAYLOAD;
        shadow_cfg.min_frame    = RST_MIN_FRAME;
        frame_state_clear();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_defaults();
        test_register_extremes();
        test_random_traffic();
        wait_idle();

        $display("sent %0d frames in %0d bytes over %0d cycles", frames_sent, bytes_sent,
                 cycle_count);
        $display("checked %0d verdicts (%0d good), %0d mismatches", verdicts_seen, good_seen,
                 mismatches);
        if (mismatches == 0 && verdict_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> crc32_frame_checker_unit.f
rtl/core/cfc_pkg.sv
rtl/core/cfc_front.sv
rtl/core/cfc_queue.sv
rtl/core/cfc_back.sv
rtl/core/crc32_frame_checker_unit.sv
verif/crc32_frame_checker_unit_test.sv
